@@ src/mac_learning_forward_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// mac learning forward table assertion macros
// shared concurrent check forms, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef MAC_LEARNING_FORWARD_TABLE_CORE_DEFINES_SVH
`define MAC_LEARNING_FORWARD_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define MLFT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MLFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/mlft_pkg.sv @@
// ----------------------------------------------------------------------------
// mlft_pkg
// types and constants shared by the forwarding table modules
// ----------------------------------------------------------------------------
package mlft_pkg;

   localparam int MAC_W     = 48;
   localparam int PORT_W    = 2;
   localparam int MASK_W    = 4;
   localparam int NUM_PORTS = 4;
   localparam int ENTRY_W   = MAC_W + PORT_W;

   localparam logic [MASK_W-1:0] PORT_ALL_MASK = MASK_W'((32'd1 << NUM_PORTS) - 32'd1);

   typedef struct packed {
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      logic [PORT_W-1:0] in_port;
   } req_type;

   typedef struct packed {
      logic              flood;
      logic [PORT_W-1:0] out_port;
      logic [MASK_W-1:0] port_mask;
      logic              learn_dropped;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

@@ src/mlft_ram.sv @@
// ----------------------------------------------------------------------------
// mlft_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mlft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mlft_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlft_ctrl
// sequencer: accept request, scan table, finish and hand off response
// ----------------------------------------------------------------------------
module mlft_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mlft_pkg::sts_type sts,
   output mlft_pkg::cmd_type cmd
);

   mlft_pkg::state_type state_ff;
   mlft_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlft_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlft_pkg::ST_IDLE: begin
            if (req_valid) state_in = mlft_pkg::ST_SCAN;
         end
         mlft_pkg::ST_SCAN: begin
            if (sts.scan_done) state_in = mlft_pkg::ST_LAST;
         end
         mlft_pkg::ST_LAST: begin
            state_in = mlft_pkg::ST_FINISH;
         end
         mlft_pkg::ST_FINISH: begin
            if (sts.out_free) state_in = mlft_pkg::ST_IDLE;
         end
         default: begin
            state_in = mlft_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd.load   = 1'b0;
      cmd.issue  = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         mlft_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         mlft_pkg::ST_SCAN: begin
            cmd.issue = !sts.scan_done;
         end
         mlft_pkg::ST_LAST: begin
         end
         mlft_pkg::ST_FINISH: begin
            cmd.finish = sts.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ src/mlft_dp.sv @@
// ----------------------------------------------------------------------------
// mlft_dp
// table ram, scan counter, match logic, learn write and response register
// ----------------------------------------------------------------------------
`include "mac_learning_forward_table_core_defines.svh"

module mlft_dp #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  mlft_pkg::req_type req_data,
   input  mlft_pkg::cmd_type cmd,
   output mlft_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mlft_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   mlft_pkg::req_type req_ff;
   mlft_pkg::rsp_type rsp_ff;
   mlft_pkg::rsp_type rsp_in;
   logic                          rsp_valid_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              idx_ff;
   logic                          rd_pend_ff;
   logic                          bound_ff;
   logic                          found_ff;
   logic [mlft_pkg::PORT_W-1:0]   best_ff;
   logic [mlft_pkg::ENTRY_W-1:0]  rd_entry;
   logic [mlft_pkg::MAC_W-1:0]    rd_mac;
   logic [mlft_pkg::PORT_W-1:0]   rd_port;
   logic                          in_port_ok;
   logic                          need_learn;
   logic                          learn_ok;
   logic                          self_hit;
   logic                          found;
   logic [mlft_pkg::PORT_W-1:0]   best;

   mlft_ram #(
      .WIDTH (mlft_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.finish && learn_ok),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_ff.src_mac, req_ff.in_port}),
      .rd_en   (cmd.issue),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   assign rd_mac  = rd_entry[mlft_pkg::ENTRY_W-1:mlft_pkg::PORT_W];
   assign rd_port = rd_entry[mlft_pkg::PORT_W-1:0];

   assign sts.scan_done = (idx_ff == count_ff);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // learn decision and final lookup, new entry included
   always_comb begin
      in_port_ok = (32'(req_ff.in_port) < mlft_pkg::NUM_PORTS);
      need_learn = in_port_ok && !bound_ff;
      learn_ok   = need_learn && (count_ff < CNT_W'(TABLE_DEPTH));
      self_hit   = learn_ok && (req_ff.src_mac == req_ff.dst_mac);
      found      = found_ff || self_hit;
      best       = best_ff;
      if (self_hit && (!found_ff || req_ff.in_port < best_ff)) begin
         best = req_ff.in_port;
      end
      rsp_in.flood         = !found;
      rsp_in.learn_dropped = need_learn && !learn_ok;
      if (found) begin
         rsp_in.out_port  = best;
         rsp_in.port_mask = mlft_pkg::MASK_W'(4'b0001 << best);
      end else begin
         rsp_in.out_port  = '0;
         rsp_in.port_mask = mlft_pkg::PORT_ALL_MASK &
            ~(in_port_ok ? mlft_pkg::MASK_W'(4'b0001 << req_ff.in_port) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.issue;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            if (learn_ok) count_ff <= count_ff + CNT_W'(1);
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_data;
         idx_ff   <= '0;
         bound_ff <= 1'b0;
         found_ff <= 1'b0;
         best_ff  <= '0;
      end else begin
         if (cmd.issue) idx_ff <= idx_ff + CNT_W'(1);
         if (rd_pend_ff) begin
            if (rd_mac == req_ff.src_mac && rd_port == req_ff.in_port) begin
               bound_ff <= 1'b1;
            end
            if (rd_mac == req_ff.dst_mac) begin
               found_ff <= 1'b1;
               if (!found_ff || rd_port < best_ff) best_ff <= rd_port;
            end
         end
      end
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MLFT_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH), "entry count over depth")
   `MLFT_ASSERT_SAME(a_issue_range, cmd.issue, idx_ff < count_ff, "read beyond learned entries")
   `MLFT_ASSERT_NEXT(a_finish_rsp, cmd.finish, rsp_valid_ff, "finish without response")
   `MLFT_ASSERT_NEXT(a_count_hold, !cmd.finish, $stable(count_ff), "count moved outside finish")

endmodule

@@ src/mac_learning_forward_table_core.sv @@
// ----------------------------------------------------------------------------
// mac_learning_forward_table_core
// learning bridge forwarding table: learns source bindings, looks up
// destination port or floods
// ----------------------------------------------------------------------------
// one request at a time: the next request is not accepted until the
// current one has scanned every learned entry and its response is
// handed to the output register; the table ram is read one entry per
// cycle in a single pass that serves both the learn check and the
// destination lookup. a finished response waits in its output register
// while the next request is already scanning. entries are never removed;
// a learn into a full table is dropped and flagged on learn_dropped.
module mac_learning_forward_table_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mlft_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mlft_pkg::rsp_type rsp_data
);

   mlft_pkg::cmd_type cmd;
   mlft_pkg::sts_type sts;

   mlft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mlft_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
